// ===== hdl/huffman_tree_decoder_unit_defines.svh =====
// Assertion helpers shared by the decoder modules.
// Each expects clk and rst_n in scope and stays quiet while reset is held.
`ifndef HUFFMAN_TREE_DECODER_UNIT_DEFINES_SVH
`define HUFFMAN_TREE_DECODER_UNIT_DEFINES_SVH

// Condition that must hold at every clock edge.
`define HTD_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define HTD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/htd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htd_pkg
// Shared widths, codes and the command format of the code tree decoder.
// ----------------------------------------------------------------------------
package htd_pkg;

  localparam int MAX_NODES_DEF     = 512;
  localparam int MAX_CODE_BITS_DEF = 16;
  localparam int CMDQ_DEPTH        = 2;

  localparam int MODE_W     = 2;
  localparam int SYM_W      = 8;
  localparam int LEN_W      = 5;
  localparam int CODE_W     = 16;
  localparam int CODE_IDX_W = $clog2(CODE_W);
  localparam int BYTE_W     = 8;
  localparam int NBITS_W    = 4;
  localparam int ST_W       = 2;
  localparam int IN_TDATA_W = 48;

  // tdata layout of an input item
  localparam int SYM_LSB   = 0;
  localparam int LEN_LSB   = SYM_LSB + SYM_W;
  localparam int CODE_LSB  = LEN_LSB + LEN_W;
  localparam int BYTE_LSB  = CODE_LSB + CODE_W;
  localparam int NBITS_LSB = BYTE_LSB + BYTE_W;

  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DECODE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_BADPATH = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

  localparam logic [NBITS_W-1:0] NBITS_MAX = 4'd8;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_DECODE = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [SYM_W-1:0]     sym;
    logic [LEN_W-1:0]     len;
    logic [CODE_W-1:0]    code;
    logic [BYTE_W-1:0]    byte_val;
    logic [NBITS_W-1:0]   nbits;
  } cmd_t;

endpackage

// ===== hdl/huffman_tree_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_decoder_unit
// Code tree builder and bit-serial decoder with stream input and output.
// ----------------------------------------------------------------------------
// Input items (in_tuser = mode): load a code entry, decode a payload byte or
// clear the tree. Results (out_tdata = symbol, out_tuser = status) leave with
// out_tlast set on the last result caused by an item.
// A front end classifies items and drops those with no effect; a two-entry
// command queue lets it keep accepting while the tree engine works.
// The engine walks one tree node per code bit; the child arrays of the node
// store share one read address and the symbol array has its own. A payload bit
// passes D_FETCH and D_CHILD, and also D_LEAF when its child exists; a decode
// takes its command in S_IDLE and flushes the last result in D_END. A load
// starts in S_IDLE, then passes L_FETCH and L_STEP for each existing node and
// L_ZERO as well for each newly created one. A clear passes through S_CLEAR.
// Reset runs a clearing pass on the root; items wait in the queue meanwhile.
// When out_tready is low, the result register and one held result fill, the
// engine stops at its next result, then the queue and in_tready.
// ----------------------------------------------------------------------------
module huffman_tree_decoder_unit #(
  parameter int MAX_NODES     = htd_pkg::MAX_NODES_DEF,
  parameter int MAX_CODE_BITS = htd_pkg::MAX_CODE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [htd_pkg::IN_TDATA_W-1:0] in_tdata,   // entry_symbol, entry_length,
                                                     // entry_code, payload_byte,
                                                     // bits_valid, zero fill
  input  logic [htd_pkg::MODE_W-1:0]     in_tuser,   // mode
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [htd_pkg::SYM_W-1:0]      out_tdata,  // symbol
  output logic [htd_pkg::ST_W-1:0]       out_tuser,  // status
  output logic                           out_tlast
);

  htd_pkg::cmd_t push_cmd, head_cmd;
  logic          q_push, q_full, q_valid, q_pop;

  htd_front #(
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_front (
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  htd_cmdq #(
    .DEPTH(htd_pkg::CMDQ_DEPTH)
  ) u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .head    (head_cmd)
  );

  htd_engine #(
    .MAX_NODES(MAX_NODES)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd       (head_cmd),
    .cmd_pop   (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_symbol(out_tdata),
    .out_status(out_tuser),
    .out_last  (out_tlast)
  );

endmodule

// ===== hdl/htd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htd_front
// Accepts input items, drops those that do nothing and queues commands.
// ----------------------------------------------------------------------------
module htd_front #(
  parameter int MAX_CODE_BITS = htd_pkg::MAX_CODE_BITS_DEF
) (
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [htd_pkg::IN_TDATA_W-1:0] in_tdata,  // entry_symbol, entry_length,
                                                    // entry_code, payload_byte,
                                                    // bits_valid, zero fill
  input  logic [htd_pkg::MODE_W-1:0]    in_tuser,  // mode
  input  logic                          q_full,
  output logic                          q_push,
  output htd_pkg::cmd_t                 q_cmd
);

  logic [htd_pkg::LEN_W-1:0]   len;
  logic [htd_pkg::NBITS_W-1:0] nbits_raw;
  logic                        keep;

  assign len       = in_tdata[htd_pkg::LEN_LSB +: htd_pkg::LEN_W];
  assign nbits_raw = in_tdata[htd_pkg::NBITS_LSB +: htd_pkg::NBITS_W];
  assign in_tready = !q_full;

  always_comb begin
    q_cmd.sym      = in_tdata[htd_pkg::SYM_LSB +: htd_pkg::SYM_W];
    q_cmd.len      = len;
    q_cmd.code     = in_tdata[htd_pkg::CODE_LSB +: htd_pkg::CODE_W];
    q_cmd.byte_val = in_tdata[htd_pkg::BYTE_LSB +: htd_pkg::BYTE_W];
    q_cmd.nbits    = (nbits_raw > htd_pkg::NBITS_MAX) ? htd_pkg::NBITS_MAX : nbits_raw;
    q_cmd.kind     = htd_pkg::CMD_CLEAR;
    keep           = 1'b0;
    case (in_tuser)
      htd_pkg::MODE_LOAD: begin
        q_cmd.kind = htd_pkg::CMD_LOAD;
        // drop empty and overlong entries
        keep = (len != '0) && (int'(len) <= MAX_CODE_BITS);
      end
      htd_pkg::MODE_DECODE: begin
        q_cmd.kind = htd_pkg::CMD_DECODE;
        keep = (nbits_raw != '0);
      end
      htd_pkg::MODE_CLEAR: begin
        q_cmd.kind = htd_pkg::CMD_CLEAR;
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push = in_tvalid && in_tready && keep;

endmodule

// ===== hdl/htd_cmdq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htd_cmdq
// Short command queue between the front end and the tree engine.
// ----------------------------------------------------------------------------
`include "huffman_tree_decoder_unit_defines.svh"

module htd_cmdq #(
  parameter int DEPTH = htd_pkg::CMDQ_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  htd_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output htd_pkg::cmd_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DepthC = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LastPtr = PTR_W'(DEPTH - 1);

  htd_pkg::cmd_t    slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == DepthC);
  assign valid   = (count_r != '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  `HTD_ASSERT(a_cmdq_count_bound, count_r <= DepthC, "command queue count above depth")

endmodule

// ===== hdl/htd_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htd_engine
// Code tree store with the load walk, the decode walk and the result register.
// ----------------------------------------------------------------------------
`include "huffman_tree_decoder_unit_defines.svh"

module htd_engine #(
  parameter int MAX_NODES = htd_pkg::MAX_NODES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_valid,
  input  htd_pkg::cmd_t               cmd,
  output logic                        cmd_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [htd_pkg::SYM_W-1:0]   out_symbol,
  output logic [htd_pkg::ST_W-1:0]    out_status,
  output logic                        out_last
);

  localparam int NW   = $clog2(MAX_NODES);
  localparam int U_W  = NW + 1;
  localparam int LF_W = htd_pkg::SYM_W + 1;
  localparam logic [U_W-1:0] MaxNodesU = U_W'(MAX_NODES);
  localparam logic [htd_pkg::LEN_W-1:0] CodeWC = htd_pkg::LEN_W'(htd_pkg::CODE_W);
  localparam logic [htd_pkg::NBITS_W-1:0] NBITS_W_ONE = htd_pkg::NBITS_W'(1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CLEAR = 9'b000000010,
    L_FETCH = 9'b000000100,
    L_STEP  = 9'b000001000,
    L_ZERO  = 9'b000010000,
    D_FETCH = 9'b000100000,
    D_CHILD = 9'b001000000,
    D_LEAF  = 9'b010000000,
    D_END   = 9'b100000000
  } state_t;

  // node store: children and {holds symbol, symbol}
  logic [NW-1:0]   left_mem  [MAX_NODES];
  logic [NW-1:0]   right_mem [MAX_NODES];
  logic [LF_W-1:0] leaf_mem  [MAX_NODES];
  logic [NW-1:0]   left_q, right_q;
  logic [LF_W-1:0] leaf_q;

  logic [NW-1:0]   rd_addr, leaf_rd_addr;
  logic            left_we, right_we, leaf_we;
  logic [NW-1:0]   left_wa, right_wa, leaf_wa;
  logic [NW-1:0]   left_wd, right_wd;
  logic [LF_W-1:0] leaf_wd;

  state_t                        state_r, state_nxt;
  logic [U_W-1:0]                nodes_used_r, nodes_used_nxt;
  logic [NW-1:0]                 walk_r, walk_nxt;
  logic [NW-1:0]                 node_r, node_nxt;
  logic [NW-1:0]                 next_r, next_nxt;
  logic [htd_pkg::SYM_W-1:0]     sym_r, sym_nxt;
  logic [htd_pkg::CODE_W-1:0]    code_r, code_nxt;
  logic [htd_pkg::LEN_W-1:0]     pos_r, pos_nxt;
  logic [htd_pkg::BYTE_W-1:0]    byte_r, byte_nxt;
  logic [htd_pkg::NBITS_W-1:0]   nbits_r, nbits_nxt;
  logic                          pend_valid_r, pend_valid_nxt;
  logic [htd_pkg::SYM_W-1:0]     pend_sym_r, pend_sym_nxt;
  logic [htd_pkg::ST_W-1:0]      pend_st_r, pend_st_nxt;
  logic                          out_valid_r;
  logic [htd_pkg::SYM_W-1:0]     out_symbol_r;
  logic [htd_pkg::ST_W-1:0]      out_status_r;
  logic                          out_last_r;

  logic                          out_free, stall;
  logic                          out_push, out_last_in;
  logic [htd_pkg::SYM_W-1:0]     out_sym_in;
  logic [htd_pkg::ST_W-1:0]      out_st_in;
  logic                          res_hit;
  logic [htd_pkg::SYM_W-1:0]     res_sym;
  logic [htd_pkg::ST_W-1:0]      res_st;
  logic                          load_bit;
  logic [NW-1:0]                 load_slot, dec_next, new_node;
  logic                          store_full;

  assign out_free   = !out_valid_r || out_ready;
  assign stall      = pend_valid_r && !out_free;
  assign load_bit   = (pos_r < CodeWC) ? code_r[pos_r[htd_pkg::CODE_IDX_W-1:0]] : 1'b0;
  assign load_slot  = load_bit ? right_q : left_q;
  assign dec_next   = byte_r[htd_pkg::BYTE_W-1] ? right_q : left_q;
  assign new_node   = nodes_used_r[NW-1:0];
  assign store_full = (nodes_used_r >= MaxNodesU);

  assign rd_addr = (state_r == L_FETCH || state_r == L_STEP || state_r == L_ZERO) ?
                   node_r : walk_r;
  assign leaf_rd_addr = (state_r == D_CHILD) ? dec_next : next_r;

  always_comb begin
    state_nxt      = state_r;
    nodes_used_nxt = nodes_used_r;
    walk_nxt       = walk_r;
    node_nxt       = node_r;
    next_nxt       = next_r;
    sym_nxt        = sym_r;
    code_nxt       = code_r;
    pos_nxt        = pos_r;
    byte_nxt       = byte_r;
    nbits_nxt      = nbits_r;
    pend_valid_nxt = pend_valid_r;
    pend_sym_nxt   = pend_sym_r;
    pend_st_nxt    = pend_st_r;
    cmd_pop        = 1'b0;
    left_we        = 1'b0;
    right_we       = 1'b0;
    leaf_we        = 1'b0;
    left_wa        = node_r;
    right_wa       = node_r;
    leaf_wa        = node_r;
    left_wd        = '0;
    right_wd       = '0;
    leaf_wd        = '0;
    out_push       = 1'b0;
    out_sym_in     = pend_sym_r;
    out_st_in      = pend_st_r;
    out_last_in    = 1'b0;
    res_hit        = 1'b0;
    res_sym        = '0;
    res_st         = htd_pkg::ST_OK;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            htd_pkg::CMD_LOAD: begin
              sym_nxt   = cmd.sym;
              code_nxt  = cmd.code;
              pos_nxt   = cmd.len - 1'b1;
              node_nxt  = '0;
              state_nxt = L_FETCH;
            end
            htd_pkg::CMD_DECODE: begin
              byte_nxt  = cmd.byte_val;
              nbits_nxt = cmd.nbits;
              state_nxt = D_FETCH;
            end
            htd_pkg::CMD_CLEAR: begin
              state_nxt = S_CLEAR;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_CLEAR: begin
        // only the root needs clearing: every other node is zeroed on allocation
        left_we        = 1'b1;
        right_we       = 1'b1;
        leaf_we        = 1'b1;
        left_wa        = '0;
        right_wa       = '0;
        leaf_wa        = '0;
        nodes_used_nxt = U_W'(1);
        walk_nxt       = '0;
        state_nxt      = S_IDLE;
      end
      L_FETCH: begin
        state_nxt = L_STEP;
      end
      L_STEP: begin
        if (load_slot != '0) begin
          if (pos_r == '0) begin
            leaf_we   = 1'b1;
            leaf_wa   = load_slot;
            leaf_wd   = {1'b1, sym_r};
            state_nxt = S_IDLE;
          end else begin
            node_nxt  = load_slot;
            pos_nxt   = pos_r - 1'b1;
            state_nxt = L_FETCH;
          end
        end else if (store_full) begin
          if (out_free) begin
            out_push    = 1'b1;
            out_sym_in  = '0;
            out_st_in   = htd_pkg::ST_FULL;
            out_last_in = 1'b1;
            state_nxt   = S_IDLE;
          end
        end else begin
          // link the new node into its parent
          if (load_bit) begin
            right_we = 1'b1;
            right_wd = new_node;
          end else begin
            left_we = 1'b1;
            left_wd = new_node;
          end
          state_nxt = L_ZERO;
        end
      end
      L_ZERO: begin
        left_we        = 1'b1;
        right_we       = 1'b1;
        leaf_we        = 1'b1;
        left_wa        = new_node;
        right_wa       = new_node;
        leaf_wa        = new_node;
        leaf_wd        = (pos_r == '0) ? {1'b1, sym_r} : '0;
        nodes_used_nxt = nodes_used_r + 1'b1;
        if (pos_r == '0) begin
          state_nxt = S_IDLE;
        end else begin
          node_nxt  = new_node;
          pos_nxt   = pos_r - 1'b1;
          state_nxt = L_FETCH;
        end
      end
      D_FETCH: begin
        state_nxt = D_CHILD;
      end
      D_CHILD: begin
        if (dec_next == '0) begin
          if (!stall) begin
            res_hit   = 1'b1;
            res_st    = htd_pkg::ST_BADPATH;
            walk_nxt  = '0;
            byte_nxt  = byte_r << 1;
            nbits_nxt = nbits_r - 1'b1;
            state_nxt = (nbits_r == NBITS_W_ONE) ? D_END : D_FETCH;
          end
        end else begin
          next_nxt  = dec_next;
          state_nxt = D_LEAF;
        end
      end
      D_LEAF: begin
        if (leaf_q[LF_W-1]) begin
          if (!stall) begin
            res_hit   = 1'b1;
            res_sym   = leaf_q[htd_pkg::SYM_W-1:0];
            res_st    = htd_pkg::ST_OK;
            walk_nxt  = '0;
            byte_nxt  = byte_r << 1;
            nbits_nxt = nbits_r - 1'b1;
            state_nxt = (nbits_r == NBITS_W_ONE) ? D_END : D_FETCH;
          end
        end else begin
          walk_nxt  = next_r;
          byte_nxt  = byte_r << 1;
          nbits_nxt = nbits_r - 1'b1;
          state_nxt = (nbits_r == NBITS_W_ONE) ? D_END : D_FETCH;
        end
      end
      D_END: begin
        // flush the held result as the last one of this item
        if (!pend_valid_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_push       = 1'b1;
          out_last_in    = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // hold each decode result back one step so the last one can be marked
    if (res_hit) begin
      if (pend_valid_r) begin
        out_push = 1'b1;
      end
      pend_valid_nxt = 1'b1;
      pend_sym_nxt   = res_sym;
      pend_st_nxt    = res_st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      nodes_used_r <= U_W'(1);
      walk_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      nodes_used_r <= nodes_used_nxt;
      walk_r       <= walk_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (out_push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    node_r     <= node_nxt;
    next_r     <= next_nxt;
    sym_r      <= sym_nxt;
    code_r     <= code_nxt;
    pos_r      <= pos_nxt;
    byte_r     <= byte_nxt;
    nbits_r    <= nbits_nxt;
    pend_sym_r <= pend_sym_nxt;
    pend_st_r  <= pend_st_nxt;
    if (out_push) begin
      out_symbol_r <= out_sym_in;
      out_status_r <= out_st_in;
      out_last_r   <= out_last_in;
    end
  end

  always_ff @(posedge clk) begin
    if (left_we) begin
      left_mem[left_wa] <= left_wd;
    end
    left_q <= left_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (right_we) begin
      right_mem[right_wa] <= right_wd;
    end
    right_q <= right_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (leaf_we) begin
      leaf_mem[leaf_wa] <= leaf_wd;
    end
    leaf_q <= leaf_mem[leaf_rd_addr];
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

  `HTD_ASSERT_IMP(a_err_sym_zero, out_valid_r && (out_status_r != htd_pkg::ST_OK), out_symbol_r == '0, "error result carries a nonzero symbol")
  `HTD_ASSERT(a_used_bound, nodes_used_r <= MaxNodesU, "node count above store size")
  `HTD_ASSERT(a_walk_alloc, {1'b0, walk_r} < nodes_used_r, "walk points at an unallocated node")
  `HTD_ASSERT_IMP(a_idle_no_pend, state_r == S_IDLE, !pend_valid_r, "held result left over in idle")

endmodule
